### hdl/tpnd_pkg.sv
// Shared types and constants for the packed note decoder.
// Used by tpnd_parser, tpnd_cleaner and tracker_packed_note_decoder_unit.
`timescale 1ns / 1ps
`default_nettype none

package tpnd_pkg;

   localparam int FIELD_COUNT  = 5;
   localparam int PHASE_WIDTH  = 3;
   localparam int MAX_NOTES    = 8192;
   localparam int POS_WIDTH    = 13;
   localparam int CSR_IDX_W    = 3;

   localparam logic [7:0] MASK_FLAG   = 8'h80;
   localparam logic [7:0] NOTE_OFF    = 8'd97;
   localparam logic [7:0] VOL_LOW_TOP = 8'h0F;
   localparam logic [7:0] VOL_VOID_LO = 8'h51;
   localparam logic [7:0] VOL_VOID_HI = 8'h5F;
   localparam logic [7:0] VOL_HIGH_LO = 8'hC0;
   localparam logic [7:0] VOL_HIGH_HI = 8'hEF;

   // Phase at which no slot is left and the note completes.
   localparam logic [PHASE_WIDTH-1:0] PHASE_DONE = PHASE_WIDTH'(FIELD_COUNT + 1);

   // Slot order within a note.
   localparam int SLOT_NOTE  = 0;
   localparam int SLOT_INST  = 1;
   localparam int SLOT_VOL   = 2;
   localparam int SLOT_EFF   = 3;
   localparam int SLOT_PARAM = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_INSTRUMENT_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_NOTE       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_INSTRUMENT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_VOLUME     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_EFFECT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_PARAM      = 3'd5;

   typedef struct packed {
      logic [7:0] instrument_count;
      logic [7:0] empty_note_code;
      logic [7:0] empty_instrument_code;
      logic [7:0] empty_volume_code;
      logic [7:0] empty_effect_code;
      logic [7:0] empty_param_code;
   } config_type;

   // A completed note as collected by the parser, before cleaning.
   typedef struct packed {
      logic [FIELD_COUNT-1:0][7:0] bytes;
      logic [FIELD_COUNT-1:0]      mask;
      logic [POS_WIDTH-1:0]        position;
   } raw_note_type;

   typedef struct packed {
      logic [7:0]           note_code;
      logic [7:0]           instrument_index;
      logic [7:0]           volume_byte;
      logic [7:0]           effect_kind;
      logic [7:0]           effect_value;
      logic [POS_WIDTH-1:0] note_position;
   } clean_note_type;

endpackage

`default_nettype wire

### hdl/tpnd_parser.sv
// Byte parser: tracks the field phase, the field mask, the stored field bytes
// and the note counter, and holds each completed note in a register. Uses tpnd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpnd_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  pattern_start,
   input  wire logic                  drain,
   output      logic                  note_valid,
   output      tpnd_pkg::raw_note_type note
);

   logic [tpnd_pkg::PHASE_WIDTH-1:0]      phase_ff, phase_in;
   logic [tpnd_pkg::FIELD_COUNT-1:0]      mask_ff, mask_in;
   logic [tpnd_pkg::FIELD_COUNT-1:0][7:0] bytes_ff, bytes_in;
   logic [tpnd_pkg::POS_WIDTH-1:0]        count_ff, count_in;
   logic                                  note_valid_ff, note_valid_in;
   tpnd_pkg::raw_note_type                note_ff, note_in;

   logic [tpnd_pkg::PHASE_WIDTH-1:0] phase_base;
   logic [tpnd_pkg::PHASE_WIDTH-1:0] phase_step;
   logic [tpnd_pkg::PHASE_WIDTH-1:0] phase_next;
   logic [tpnd_pkg::POS_WIDTH-1:0]   count_base;
   logic [tpnd_pkg::FIELD_COUNT-1:0] mask_new;
   logic [2:0]                       slot;
   logic                             done;

   always_comb begin
      phase_base = pattern_start ? '0 : phase_ff;
      count_base = pattern_start ? '0 : count_ff;
      mask_new   = pattern_start ? '0 : mask_ff;
      bytes_in   = bytes_ff;
      slot       = phase_base - 3'd1;
      if (phase_base == '0) begin
         if ((data_byte & tpnd_pkg::MASK_FLAG) != 8'h00) begin
            mask_new   = data_byte[tpnd_pkg::FIELD_COUNT-1:0];
            phase_step = 3'd1;
         end else begin
            mask_new   = '1;
            bytes_in[tpnd_pkg::SLOT_NOTE] = data_byte;
            phase_step = 3'd2;
         end
      end else begin
         if (phase_base <= 3'(tpnd_pkg::FIELD_COUNT)) begin
            bytes_in[slot] = data_byte;
         end
         phase_step = phase_base + 3'd1;
      end

      // Skip to the next slot whose mask bit is set, if any is left.
      phase_next = tpnd_pkg::PHASE_DONE;
      for (int q = tpnd_pkg::FIELD_COUNT; q >= 1; q--) begin
         if ((3'(q) >= phase_step) && mask_new[q-1]) begin
            phase_next = 3'(q);
         end
      end
      done = (phase_next == tpnd_pkg::PHASE_DONE);

      phase_in = done ? '0 : phase_next;
      mask_in  = done ? '0 : mask_new;
      if (!done) begin
         count_in = count_base;
      end else if (count_base == tpnd_pkg::POS_WIDTH'(tpnd_pkg::MAX_NOTES - 1)) begin
         count_in = '0;
      end else begin
         count_in = count_base + 1'b1;
      end

      note_in.bytes    = bytes_in;
      note_in.mask     = mask_new;
      note_in.position = count_base;

      if (accept && done) begin
         note_valid_in = 1'b1;
      end else if (drain) begin
         note_valid_in = 1'b0;
      end else begin
         note_valid_in = note_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         mask_ff       <= '0;
         count_ff      <= '0;
         note_valid_ff <= 1'b0;
      end else begin
         note_valid_ff <= note_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            mask_ff  <= mask_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bytes_ff <= bytes_in;
         if (done) begin
            note_ff <= note_in;
         end
      end
   end

   assign note_valid = note_valid_ff;
   assign note       = note_ff;

endmodule

`default_nettype wire

### hdl/tpnd_cleaner.sv
// Field cleaning and result register: applies sentinels and range fixes to a
// collected note and holds the result for the response channel. Uses tpnd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpnd_cleaner (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tpnd_pkg::config_type     cfg,
   input  wire logic                    note_valid,
   input  wire tpnd_pkg::raw_note_type   note,
   input  wire logic                    rsp_stall,
   output      logic                    load,
   output      logic                    rsp_valid,
   output      tpnd_pkg::clean_note_type result
);

   logic                     valid_ff, valid_in;
   tpnd_pkg::clean_note_type result_ff, result_in;

   logic [7:0] note_raw, inst_raw, vol_raw, eff_raw, par_raw;
   logic [7:0] eff_fix, vol_a, vol_b;

   always_comb begin
      note_raw = note.mask[tpnd_pkg::SLOT_NOTE] ?
                 note.bytes[tpnd_pkg::SLOT_NOTE] : cfg.empty_note_code;
      inst_raw = note.mask[tpnd_pkg::SLOT_INST] ?
                 note.bytes[tpnd_pkg::SLOT_INST] : cfg.empty_instrument_code;
      vol_raw  = note.mask[tpnd_pkg::SLOT_VOL] ?
                 note.bytes[tpnd_pkg::SLOT_VOL] : cfg.empty_volume_code;
      eff_raw  = note.mask[tpnd_pkg::SLOT_EFF] ?
                 note.bytes[tpnd_pkg::SLOT_EFF] : cfg.empty_effect_code;
      par_raw  = note.mask[tpnd_pkg::SLOT_PARAM] ?
                 note.bytes[tpnd_pkg::SLOT_PARAM] : cfg.empty_param_code;

      // A parameter without an effect type is an arpeggio.
      eff_fix = ((eff_raw == cfg.empty_effect_code) && (par_raw != cfg.empty_param_code)) ?
                8'h00 : eff_raw;

      if (note_raw == 8'h00) begin
         result_in.note_code = cfg.empty_note_code;
      end else if ((note_raw > tpnd_pkg::NOTE_OFF) && (note_raw != cfg.empty_note_code)) begin
         result_in.note_code = cfg.empty_note_code;
      end else begin
         result_in.note_code = note_raw;
      end

      if ((inst_raw != 8'h00) && (inst_raw <= cfg.instrument_count)) begin
         result_in.instrument_index = inst_raw - 8'd1;
      end else begin
         result_in.instrument_index = cfg.empty_instrument_code;
      end

      // The volume checks chain, so a sentinel may itself fall into a later range.
      vol_a = (vol_raw <= tpnd_pkg::VOL_LOW_TOP) ? 8'h00 : vol_raw;
      vol_b = ((vol_a >= tpnd_pkg::VOL_VOID_LO) && (vol_a <= tpnd_pkg::VOL_VOID_HI)) ?
              cfg.empty_volume_code : vol_a;
      result_in.volume_byte = ((vol_b >= tpnd_pkg::VOL_HIGH_LO) &&
                               (vol_b <= tpnd_pkg::VOL_HIGH_HI)) ? 8'h00 : vol_b;

      result_in.effect_kind  = eff_fix;
      result_in.effect_value = ((eff_fix != cfg.empty_effect_code) &&
                                (par_raw == cfg.empty_param_code)) ? 8'h00 : par_raw;
      result_in.note_position = note.position;
   end

   assign load     = !valid_ff || !rsp_stall;
   assign valid_in = load ? note_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && note_valid) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign result    = result_ff;

endmodule

`default_nettype wire

### hdl/tracker_packed_note_decoder_unit.sv
// Top level of the packed note decoder: configuration registers, handshake
// glue and the parser and cleaner stages. Uses tpnd_pkg, tpnd_parser, tpnd_cleaner.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    data_byte, pattern_start
//   rsp      out        rsp_valid/stall    note, instrument, volume, effect, param, position
//   csr      in         csr_write_enable   csr_index, csr_write_data
//
// One byte is taken per cycle while the input is not stalled. A byte that
// completes a note passes the note register of the parser and then the
// result register of the cleaner before it reaches the response port.
// Synchronous reset clears the parser and the counter and sets the configuration to its defaults.
// Input stalls only while both note registers are full and the response is stalled.
`timescale 1ns / 1ps
`default_nettype none

module tracker_packed_note_decoder_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic                          req_pattern_start,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [7:0]                    rsp_note_code,
   output      logic [7:0]                    rsp_instrument_index,
   output      logic [7:0]                    rsp_volume_byte,
   output      logic [7:0]                    rsp_effect_kind,
   output      logic [7:0]                    rsp_effect_value,
   output      logic [tpnd_pkg::POS_WIDTH-1:0] rsp_note_position,
   input  wire logic                          csr_write_enable,
   input  wire logic [tpnd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]                    csr_write_data
);

   tpnd_pkg::config_type     cfg_ff, cfg_in;
   tpnd_pkg::raw_note_type   note;
   tpnd_pkg::clean_note_type result;
   logic                     note_valid;
   logic                     load;
   logic                     accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            tpnd_pkg::CSR_INSTRUMENT_COUNT: cfg_in.instrument_count      = csr_write_data;
            tpnd_pkg::CSR_EMPTY_NOTE:       cfg_in.empty_note_code       = csr_write_data;
            tpnd_pkg::CSR_EMPTY_INSTRUMENT: cfg_in.empty_instrument_code = csr_write_data;
            tpnd_pkg::CSR_EMPTY_VOLUME:     cfg_in.empty_volume_code     = csr_write_data;
            tpnd_pkg::CSR_EMPTY_EFFECT:     cfg_in.empty_effect_code     = csr_write_data;
            tpnd_pkg::CSR_EMPTY_PARAM:      cfg_in.empty_param_code      = csr_write_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.instrument_count      <= 8'd0;
         cfg_ff.empty_note_code       <= 8'd255;
         cfg_ff.empty_instrument_code <= 8'd255;
         cfg_ff.empty_volume_code     <= 8'd255;
         cfg_ff.empty_effect_code     <= 8'd255;
         cfg_ff.empty_param_code      <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A new byte may only enter when the note register is empty or can pass its contents on.
   assign req_stall = note_valid && !load;
   assign accept    = req_valid && !req_stall;

   tpnd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .pattern_start (req_pattern_start),
      .drain         (load),
      .note_valid    (note_valid),
      .note          (note)
   );

   tpnd_cleaner u_cleaner (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .note_valid (note_valid),
      .note       (note),
      .rsp_stall  (rsp_stall),
      .load       (load),
      .rsp_valid  (rsp_valid),
      .result     (result)
   );

   assign rsp_note_code        = result.note_code;
   assign rsp_instrument_index = result.instrument_index;
   assign rsp_volume_byte      = result.volume_byte;
   assign rsp_effect_kind      = result.effect_kind;
   assign rsp_effect_value     = result.effect_value;
   assign rsp_note_position    = result.note_position;

endmodule

`default_nettype wire
